FILE: hdl/whp_pkg.sv
// ----------------------------------------------------------------------------
// whp_pkg: shared types and constants of the WAV header parser
// Header phases, queue commands, result layout and marker words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package whp_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;
  localparam int DIV_W       = 35;
  localparam logic [5:0] DIV_STEPS = 6'd35;

  localparam logic [31:0] MARK_RIFF = 32'h4646_4952;  // "RIFF", little endian
  localparam logic [31:0] MARK_WAVE = 32'h4556_4157;  // "WAVE"
  localparam logic [31:0] MARK_FMT  = 32'h2074_6D66;  // "fmt "
  localparam logic [31:0] MARK_DATA = 32'h6174_6164;  // "data"
  localparam logic [15:0] FMT_PCM      = 16'd1;
  localparam logic [31:0] FMT_BASE_LEN = 32'd16;

  typedef enum logic [15:0] {
    PH_RIFF    = 16'h0001,
    PH_FSIZE   = 16'h0002,
    PH_WAVE    = 16'h0004,
    PH_FMT     = 16'h0008,
    PH_FMTLEN  = 16'h0010,
    PH_FTYPE   = 16'h0020,
    PH_CHAN    = 16'h0040,
    PH_RATE    = 16'h0080,
    PH_BRATE   = 16'h0100,
    PH_ALIGN   = 16'h0200,
    PH_BITS    = 16'h0400,
    PH_SKIP    = 16'h0800,
    PH_DMARK   = 16'h1000,
    PH_DSIZE   = 16'h2000,
    PH_PAYLOAD = 16'h4000,
    PH_HALT    = 16'h8000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_META = 2'd0,
    KIND_DATA = 2'd1,
    KIND_ERR  = 2'd2,
    KIND_DONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_RIFF = 3'd0,
    ERR_WAVE = 3'd1,
    ERR_FMT  = 3'd2,
    ERR_PCM  = 3'd3,
    ERR_DATA = 3'd4,
    ERR_ZERO = 3'd5
  } err_t;

  typedef enum logic [1:0] {
    CMD_META = 2'd0,
    CMD_DATA = 2'd1,
    CMD_ERR  = 2'd2
  } cmd_op_t;

  // One queue entry: value is the payload byte or the error code
  typedef struct packed {
    cmd_op_t     op;
    logic [7:0]  value;
    logic        done;
    logic [31:0] size;
  } cmd_t;

  // Format fields held by the front, stable once the data size is in
  typedef struct packed {
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] bits;
  } hdr_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [34:0] frame_count;
    err_t        error_code;
    logic        last;
  } res_t;

  // Bytes in each header field
  function automatic logic [2:0] field_len(phase_t ph);
    logic [2:0] n;
    case (ph)
      PH_FTYPE, PH_CHAN, PH_ALIGN, PH_BITS: n = 3'd2;
      PH_SKIP, PH_PAYLOAD, PH_HALT:         n = 3'd0;
      default:                              n = 3'd4;
    endcase
    return n;
  endfunction

  function automatic res_t make_res(kind_t k, logic [7:0] b, err_t code, logic lst);
    res_t r;
    r = '0;
    r.kind       = k;
    r.data_byte  = b;
    r.error_code = code;
    r.last       = lst;
    return r;
  endfunction

endpackage

FILE: hdl/whp_front.sv
// ----------------------------------------------------------------------------
// whp_front: header walker
// Accepts file bytes, checks markers, gathers format fields and queues
// metadata, payload and error commands for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module whp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  output logic            push,
  output whp_pkg::cmd_t   push_cmd,
  input  logic            q_full,
  output whp_pkg::hdr_t   hdr
);

  whp_pkg::phase_t phase, phase_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [31:0] field_shift, field_shift_next;
  logic [15:0] channels_held, channels_held_next;
  logic [31:0] rate_held, rate_held_next;
  logic [15:0] bits_held, bits_held_next;
  logic [31:0] fmt_length, fmt_length_next;
  logic [31:0] skip_left, skip_left_next;
  logic [31:0] data_left, data_left_next;
  logic        accept;
  logic [31:0] word;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign word     = {in_byte, field_shift[31:8]};

  assign hdr.channels = channels_held;
  assign hdr.rate     = rate_held;
  assign hdr.bits     = bits_held;

  always_comb begin
    phase_next         = phase;
    byte_index_next    = byte_index;
    field_shift_next   = field_shift;
    channels_held_next = channels_held;
    rate_held_next     = rate_held;
    bits_held_next     = bits_held;
    fmt_length_next    = fmt_length;
    skip_left_next     = skip_left;
    data_left_next     = data_left;
    push               = 1'b0;
    push_cmd           = '0;
    if (accept) begin
      case (phase)
        whp_pkg::PH_HALT: begin
        end
        whp_pkg::PH_SKIP: begin
          skip_left_next = skip_left - 32'd1;
          if (skip_left == 32'd1) begin
            phase_next      = whp_pkg::PH_DMARK;
            byte_index_next = 2'd0;
          end
        end
        whp_pkg::PH_PAYLOAD: begin
          push           = 1'b1;
          push_cmd.op    = whp_pkg::CMD_DATA;
          push_cmd.value = in_byte;
          push_cmd.done  = (data_left == 32'd1);
          data_left_next = data_left - 32'd1;
          if (data_left == 32'd1) begin
            phase_next = whp_pkg::PH_HALT;
          end
        end
        default: begin
          field_shift_next = word;
          if ({1'b0, byte_index} + 3'd1 < whp_pkg::field_len(phase)) begin
            byte_index_next = byte_index + 2'd1;
          end else begin
            byte_index_next = 2'd0;
            // field complete: judge it and move on
            case (phase)
              whp_pkg::PH_RIFF: begin
                if (word != whp_pkg::MARK_RIFF) begin
                  push           = 1'b1;
                  push_cmd.op    = whp_pkg::CMD_ERR;
                  push_cmd.value = {5'd0, whp_pkg::ERR_RIFF};
                  phase_next     = whp_pkg::PH_HALT;
                end else begin
                  phase_next = whp_pkg::PH_FSIZE;
                end
              end
              whp_pkg::PH_FSIZE: phase_next = whp_pkg::PH_WAVE;
              whp_pkg::PH_WAVE: begin
                if (word != whp_pkg::MARK_WAVE) begin
                  push           = 1'b1;
                  push_cmd.op    = whp_pkg::CMD_ERR;
                  push_cmd.value = {5'd0, whp_pkg::ERR_WAVE};
                  phase_next     = whp_pkg::PH_HALT;
                end else begin
                  phase_next = whp_pkg::PH_FMT;
                end
              end
              whp_pkg::PH_FMT: begin
                if (word != whp_pkg::MARK_FMT) begin
                  push           = 1'b1;
                  push_cmd.op    = whp_pkg::CMD_ERR;
                  push_cmd.value = {5'd0, whp_pkg::ERR_FMT};
                  phase_next     = whp_pkg::PH_HALT;
                end else begin
                  phase_next = whp_pkg::PH_FMTLEN;
                end
              end
              whp_pkg::PH_FMTLEN: begin
                fmt_length_next = word;
                phase_next      = whp_pkg::PH_FTYPE;
              end
              whp_pkg::PH_FTYPE: begin
                if (word[31:16] != whp_pkg::FMT_PCM) begin
                  push           = 1'b1;
                  push_cmd.op    = whp_pkg::CMD_ERR;
                  push_cmd.value = {5'd0, whp_pkg::ERR_PCM};
                  phase_next     = whp_pkg::PH_HALT;
                end else begin
                  phase_next = whp_pkg::PH_CHAN;
                end
              end
              whp_pkg::PH_CHAN: begin
                channels_held_next = word[31:16];
                phase_next         = whp_pkg::PH_RATE;
              end
              whp_pkg::PH_RATE: begin
                rate_held_next = word;
                phase_next     = whp_pkg::PH_BRATE;
              end
              whp_pkg::PH_BRATE: phase_next = whp_pkg::PH_ALIGN;
              whp_pkg::PH_ALIGN: phase_next = whp_pkg::PH_BITS;
              whp_pkg::PH_BITS: begin
                bits_held_next = word[31:16];
                if (fmt_length > whp_pkg::FMT_BASE_LEN) begin
                  skip_left_next = fmt_length - whp_pkg::FMT_BASE_LEN;
                  phase_next     = whp_pkg::PH_SKIP;
                end else begin
                  skip_left_next = 32'd0;
                  phase_next     = whp_pkg::PH_DMARK;
                end
              end
              whp_pkg::PH_DMARK: begin
                if (word != whp_pkg::MARK_DATA) begin
                  push           = 1'b1;
                  push_cmd.op    = whp_pkg::CMD_ERR;
                  push_cmd.value = {5'd0, whp_pkg::ERR_DATA};
                  phase_next     = whp_pkg::PH_HALT;
                end else begin
                  phase_next = whp_pkg::PH_DSIZE;
                end
              end
              whp_pkg::PH_DSIZE: begin
                data_left_next = word;
                push           = 1'b1;
                if (channels_held == 16'd0 || bits_held == 16'd0) begin
                  push_cmd.op    = whp_pkg::CMD_ERR;
                  push_cmd.value = {5'd0, whp_pkg::ERR_ZERO};
                  phase_next     = whp_pkg::PH_HALT;
                end else begin
                  push_cmd.op   = whp_pkg::CMD_META;
                  push_cmd.size = word;
                  push_cmd.done = (word == 32'd0);
                  phase_next    = (word == 32'd0) ? whp_pkg::PH_HALT : whp_pkg::PH_PAYLOAD;
                end
              end
              default: phase_next = whp_pkg::PH_HALT;
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= whp_pkg::PH_RIFF;
      byte_index    <= 2'd0;
      field_shift   <= 32'd0;
      channels_held <= 16'd0;
      rate_held     <= 32'd0;
      bits_held     <= 16'd0;
      fmt_length    <= 32'd0;
      skip_left     <= 32'd0;
      data_left     <= 32'd0;
    end else begin
      phase         <= phase_next;
      byte_index    <= byte_index_next;
      field_shift   <= field_shift_next;
      channels_held <= channels_held_next;
      rate_held     <= rate_held_next;
      bits_held     <= bits_held_next;
      fmt_length    <= fmt_length_next;
      skip_left     <= skip_left_next;
      data_left     <= data_left_next;
    end
  end

endmodule

FILE: hdl/whp_queue.sv
// ----------------------------------------------------------------------------
// whp_queue: command queue between header walker and result engine
// Small ring buffer; one push per cycle unless full, one pop unless empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module whp_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  whp_pkg::cmd_t         push_cmd,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output whp_pkg::cmd_t         head
);

  whp_pkg::cmd_t mem [whp_pkg::QUEUE_DEPTH];
  logic [whp_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [whp_pkg::QCNT_W-1:0] count;
  logic do_push, do_pop;

  assign full    = (count == whp_pkg::QCNT_W'(whp_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/whp_back.sv
// ----------------------------------------------------------------------------
// whp_back: result engine
// Drains the command queue into the output register; runs the frame count
// through a shared bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module whp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  whp_pkg::cmd_t   q_head,
  output logic            q_pop,
  input  whp_pkg::hdr_t   hdr,
  output logic            out_valid,
  input  logic            out_ready,
  output whp_pkg::res_t   out_res
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_DIV1 = 5'b00010,
    B_DIV2 = 5'b00100,
    B_META = 5'b01000,
    B_DONE = 5'b10000
  } bstate_t;

  bstate_t state;
  logic                      done_pend;
  logic [whp_pkg::DIV_W-1:0] dvd;
  logic [15:0]               rem;
  logic [5:0]                count;
  logic                      out_free;
  logic [16:0]               rem_sh, divisor, rem_sub;
  logic                      ge;
  logic [15:0]               rem_new;
  logic                      last_step;
  logic                      load;
  whp_pkg::res_t             meta_res;

  assign out_free  = !out_valid || out_ready;
  assign q_pop     = (state == B_IDLE) && !q_empty && out_free;
  assign last_step = (count == whp_pkg::DIV_STEPS - 6'd1);

  // a new item enters the output register this cycle
  assign load = (q_pop && (q_head.op inside {whp_pkg::CMD_DATA, whp_pkg::CMD_ERR}))
             || ((state == B_META || state == B_DONE) && out_free);

  // restoring division step
  always_comb begin
    rem_sh  = {rem, dvd[whp_pkg::DIV_W-1]};
    divisor = (state == B_DIV1) ? {1'b0, hdr.channels} : {1'b0, hdr.bits};
    ge      = (rem_sh >= divisor);
    rem_sub = rem_sh - divisor;
    rem_new = ge ? rem_sub[15:0] : rem_sh[15:0];
  end

  always_comb begin
    meta_res               = '0;
    meta_res.kind          = whp_pkg::KIND_META;
    meta_res.channel_count = hdr.channels;
    meta_res.sample_rate   = hdr.rate;
    meta_res.sample_bits   = hdr.bits;
    meta_res.frame_count   = dvd;
    meta_res.error_code    = whp_pkg::ERR_RIFF;
    meta_res.last          = !done_pend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      done_pend <= 1'b0;
      count     <= 6'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_pop) begin
            case (q_head.op)
              whp_pkg::CMD_DATA: begin
                out_res <= whp_pkg::make_res(whp_pkg::KIND_DATA, q_head.value,
                                             whp_pkg::ERR_RIFF, !q_head.done);
                if (q_head.done) state <= B_DONE;
              end
              whp_pkg::CMD_ERR: begin
                out_res <= whp_pkg::make_res(whp_pkg::KIND_ERR, 8'd0,
                                             whp_pkg::err_t'(q_head.value[2:0]), 1'b1);
              end
              whp_pkg::CMD_META: begin
                dvd       <= {3'b000, q_head.size};
                rem       <= 16'd0;
                count     <= 6'd0;
                done_pend <= q_head.done;
                state     <= B_DIV1;
              end
              default: begin
              end
            endcase
          end
        end
        B_DIV1: begin
          if (last_step) begin
            // size / channels, times eight, is the second dividend
            dvd   <= {dvd[30:0], ge, 3'b000};
            rem   <= 16'd0;
            count <= 6'd0;
            state <= B_DIV2;
          end else begin
            rem   <= rem_new;
            count <= count + 6'd1;
            dvd   <= {dvd[whp_pkg::DIV_W-2:0], ge};
          end
        end
        B_DIV2: begin
          rem   <= rem_new;
          count <= count + 6'd1;
          dvd   <= {dvd[whp_pkg::DIV_W-2:0], ge};
          if (last_step) state <= B_META;
        end
        B_META: begin
          if (out_free) begin
            out_res <= meta_res;
            state   <= done_pend ? B_DONE : B_IDLE;
          end
        end
        B_DONE: begin
          if (out_free) begin
            out_res <= whp_pkg::make_res(whp_pkg::KIND_DONE, 8'd0,
                                         whp_pkg::ERR_RIFF, 1'b1);
            state   <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/wav_header_parser_top.sv
// ----------------------------------------------------------------------------
// wav_header_parser_top: RIFF/WAVE PCM header parser
// Walks a WAV file byte by byte, reports the format once, then forwards
// the audio payload and a closing done item; a bad header ends in an error item.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                                   | tuser     | tlast
//  --------+-----+-----------------------------------------+-----------+------
//  s_axis  | in  | file byte [7:0]                         | -         | -
//  m_axis  | out | byte, channels, rate, bits, frames, err | kind[1:0] | last
//
//  Header and payload bytes are taken one per cycle while the command queue
//  has room. The frame count holds the result engine from dequeue to the
//  metadata item (the load, two 35-step divisions through one bit-serial
//  divider, then the format step), once per file; the four-entry queue
//  lets the walker run up to four commands ahead meanwhile. Each payload
//  byte then leaves one per cycle while m_tready is high. Reset is synchronous;
//  there is no clearing pass. A stalled m_tready backs up the queue, then s_tready.
//
`timescale 1ns / 1ps

module wav_header_parser_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // [7:0] in_byte
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [111:0]  m_tdata,   // [7:0] data_byte, [23:8] channel_count,
                                   // [55:24] sample_rate, [71:56] sample_bits,
                                   // [106:72] frame_count, [109:107] error_code,
                                   // [111:110] zero
  output logic [1:0]    m_tuser,   // [1:0] kind
  output logic          m_tlast
);

  logic           push, q_full, q_empty, q_pop;
  whp_pkg::cmd_t  push_cmd, q_head;
  whp_pkg::hdr_t  hdr;
  whp_pkg::res_t  res;

  // front: classify bytes and queue commands
  whp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full),
    .hdr      (hdr)
  );

  // decouple walker from result engine
  whp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // back: divide, format and hold the result
  whp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .hdr       (hdr),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // pack result, lowest field first
  assign m_tdata = {2'b00, res.error_code, res.frame_count, res.sample_bits,
                    res.sample_rate, res.channel_count, res.data_byte};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

endmodule

FILE: hdl/whp_checker.sv
// ----------------------------------------------------------------------------
// whp_checker: port-level checks of the WAV header parser
// Watches the result stream; attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module whp_checker (
  input logic          clk,
  input logic          rst,
  input logic          m_tvalid,
  input logic          m_tready,
  input logic [111:0]  m_tdata,
  input logic [1:0]    m_tuser,
  input logic          m_tlast
);

  // hold a stalled item
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled result changed");

  // no result right after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

  // error and done close the stream
  a_final: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == whp_pkg::KIND_ERR || m_tuser == whp_pkg::KIND_DONE)
    |-> m_tlast)
    else $error("error or done without last");

  // a payload item carries only its byte
  a_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == whp_pkg::KIND_DATA |-> m_tdata[111:8] == '0)
    else $error("payload item carries header fields");

  // a done item shows up right after an accepted payload or metadata item
  a_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == whp_pkg::KIND_DONE
    && !$past(m_tvalid && m_tuser == whp_pkg::KIND_DONE)
    |-> $past(m_tvalid && m_tready)
        && ($past(m_tuser) == whp_pkg::KIND_DATA || $past(m_tuser) == whp_pkg::KIND_META))
    else $error("done without preceding item");

endmodule

bind wav_header_parser_top whp_checker u_whp_checker (.*);
